/* rtl/sds_pkg.sv */
// Shared package for the dual stack core: action codes and fixed field widths.
package sds_pkg;

  // Action codes carried by the action field
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  // Fixed payload widths
  localparam int ACT_W   = 2;
  localparam int DATA_W  = 32;
  localparam int LEVEL_W = 5;

endpackage

/* rtl/sds_store.sv */
// Word store shared by both stacks: one port, synchronous write, registered read.
module sds_store
  import sds_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write on we, capture the read word on re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/shared_dual_stack_core.sv */
// Top level of the dual stack core: two LIFO stacks sharing one word store.
//
//   channel   signals                                       transfer
//   --------  --------------------------------------------  ------------------------
//   command   start, action, stack_select, push_value      edge with start && !busy
//   result    done, ok, read_value, low_depth, high_depth,  edge ending the done cycle
//             all_empty
//
// A push completes in the EXEC state, which registers its done strobe; a pop or
// peek that reads the store also passes through READ, set by the registered read
// port of the store. A refused operation or an unknown action code ends in EXEC.
// busy is high from the accepting edge until the result is driven.
// rst is synchronous: it empties both stacks; store contents stay undefined.
// The receiver cannot stall; done is high for exactly one cycle per item.
module shared_dual_stack_core
  import sds_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         action,
  input  logic                     stack_select,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     done,
  output logic                     ok,
  output logic signed [DATA_W-1:0] read_value,
  output logic [LEVEL_W-1:0]       low_depth,
  output logic [LEVEL_W-1:0]       high_depth,
  output logic                     all_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]        state, state_next;
  logic [ACT_W-1:0]  op_action;
  logic              op_sel;
  logic [DATA_W-1:0] op_value;
  logic [CW-1:0]     low_count, low_count_next;
  logic [CW-1:0]     high_count, high_count_next;

  logic              full;
  logic              sel_nonempty;
  logic              is_read_op;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  logic [CW-1:0]     addr_wide;

  logic                     done_next, ok_next;
  logic signed [DATA_W-1:0] read_value_next;

  assign busy = (state != S_IDLE);

  // Occupancy checks on the current counts
  assign full = (({1'b0, low_count} + {1'b0, high_count}) >= (CW+1)'(DEPTH));
  assign sel_nonempty = op_sel ? (high_count != '0) : (low_count != '0);
  assign is_read_op = (op_action == ACT_POP) || (op_action == ACT_PEEK);

  // Pick the entry touched by this operation
  always_comb begin
    if (op_action == ACT_PUSH) begin
      addr_wide = op_sel ? (CW'(DEPTH - 1) - high_count) : low_count;
    end else begin
      addr_wide = op_sel ? (CW'(DEPTH) - high_count) : (low_count - CW'(1));
    end
  end
  assign mem_addr = AW'(addr_wide);
  assign mem_we = (state == S_EXEC) && (op_action == ACT_PUSH) && !full;
  assign mem_re = (state == S_EXEC) && is_read_op && sel_nonempty;

  sds_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (op_value),
    .rdata (mem_rdata)
  );

  // Sequence one operation: execute, then read back when the store is read
  always_comb begin
    state_next      = state;
    low_count_next  = low_count;
    high_count_next = high_count;
    done_next       = 1'b0;
    ok_next         = 1'b0;
    read_value_next = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mem_we) begin
          if (op_sel) begin
            high_count_next = high_count + CW'(1);
          end else begin
            low_count_next = low_count + CW'(1);
          end
          ok_next    = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (mem_re) begin
          if (op_action == ACT_POP) begin
            if (op_sel) begin
              high_count_next = high_count - CW'(1);
            end else begin
              low_count_next = low_count - CW'(1);
            end
          end
          state_next = S_READ;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        ok_next         = 1'b1;
        read_value_next = $signed(mem_rdata);
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      low_count  <= '0;
      high_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      low_count  <= low_count_next;
      high_count <= high_count_next;
      done       <= done_next;
    end
  end

  // Hold the command and drive the result registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_action <= action;
      op_sel    <= stack_select;
      op_value  <= push_value;
    end
    if (done_next) begin
      ok         <= ok_next;
      read_value <= read_value_next;
      low_depth  <= LEVEL_W'(low_count_next);
      high_depth <= LEVEL_W'(high_count_next);
      all_empty  <= (low_count_next == '0) && (high_count_next == '0);
    end
  end

`ifndef SYNTHESIS
  // The result strobe comes only once the core is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // The two stacks never hold more than the store
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, low_count} + {1'b0, high_count}) <= (CW+1)'(DEPTH))
    else $error("stack counts exceed store depth");

  // An accepted command keeps the core busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but core not busy");

  // One strobe per item
  a_single_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back result strobes");

  // The store is read only for a pop or peek on a non-empty stack
  a_read_guard: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (sel_nonempty && !mem_we))
    else $error("store read on an empty stack");
`endif

endmodule

/* test/shared_dual_stack_core_tb.sv */
// Self-checking testbench for shared_dual_stack_core: push/pop/peek traffic against a stack predictor.
`timescale 1ns / 100ps

module shared_dual_stack_core_tb;
  import sds_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_TAIL = 100;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  read_value;
    logic [LEVEL_W-1:0] low_depth;
    logic [LEVEL_W-1:0] high_depth;
    logic               all_empty;
  } stack_result_t;

  // Predict each transfer's result and compare against the strobed outputs
  class stack_scoreboard;
    int unsigned slots;
    logic [DATA_W-1:0] words[];
    int unsigned low_cnt;
    int unsigned high_cnt;
    stack_result_t pending[$];
    int errors;

    function new(int unsigned n);
      slots = n;
      words = new[n];
      low_cnt = 0;
      high_cnt = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_command(logic [ACT_W-1:0] act, logic sel, logic [DATA_W-1:0] val);
      stack_result_t res;
      res = '0;
      case (act)
        ACT_PUSH: begin
          if (low_cnt + high_cnt < slots) begin
            if (!sel) begin
              words[low_cnt] = val;
              low_cnt++;
            end else begin
              high_cnt++;
              words[slots - high_cnt] = val;
            end
            res.ok = 1'b1;
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (!sel && low_cnt != 0) begin
            res.read_value = words[low_cnt - 1];
            if (act == ACT_POP) low_cnt--;
            res.ok = 1'b1;
          end else if (sel && high_cnt != 0) begin
            res.read_value = words[slots - high_cnt];
            if (act == ACT_POP) high_cnt--;
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.low_depth = low_cnt[LEVEL_W-1:0];
      res.high_depth = high_cnt[LEVEL_W-1:0];
      res.all_empty = (low_cnt == 0 && high_cnt == 0);
      pending.push_back(res);
    endfunction

    function void check_result(logic r_ok, logic [DATA_W-1:0] r_rd, logic [LEVEL_W-1:0] r_lo,
                               logic [LEVEL_W-1:0] r_hi, logic r_ae);
      stack_result_t want;
      if (pending.size() == 0) begin
        $error("result with no pending transfer: ok=%0d read_value=%h", r_ok, r_rd);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (r_ok !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, r_ok);
        errors++;
      end
      if (r_rd !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, r_rd);
        errors++;
      end
      if (r_lo !== want.low_depth) begin
        $error("low_depth: expected %0d, actual %0d", want.low_depth, r_lo);
        errors++;
      end
      if (r_hi !== want.high_depth) begin
        $error("high_depth: expected %0d, actual %0d", want.high_depth, r_hi);
        errors++;
      end
      if (r_ae !== want.all_empty) begin
        $error("all_empty: expected %0d, actual %0d", want.all_empty, r_ae);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [ACT_W-1:0]         action;
  logic                     stack_select;
  logic signed [DATA_W-1:0] push_value;
  logic                     done;
  logic                     ok;
  logic signed [DATA_W-1:0] read_value;
  logic [LEVEL_W-1:0]       low_depth;
  logic [LEVEL_W-1:0]       high_depth;
  logic                     all_empty;
  int                       cycles;

  stack_scoreboard sb = new(STORE_DEPTH);

  shared_dual_stack_core #(.DEPTH(STORE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .stack_select(stack_select),
    .push_value(push_value),
    .done(done),
    .ok(ok),
    .read_value(read_value),
    .low_depth(low_depth),
    .high_depth(high_depth),
    .all_empty(all_empty)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(ok, read_value, low_depth, high_depth, all_empty);
  end

  // Present one command at a falling edge and hold it until the transfer
  task automatic send_cmd(logic [ACT_W-1:0] act, logic sel, logic [DATA_W-1:0] val);
    start <= 1'b1;
    action <= act;
    stack_select <= sel;
    push_value <= val;
    do @(posedge clk); while (busy);
    sb.note_command(act, sel, val);
    @(negedge clk);
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold off until every pending result has arrived
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    int push_pct;
    int r;
    logic [ACT_W-1:0] act;

    rst = 1'b1;
    start = 1'b0;
    action = ACT_PUSH;
    stack_select = 1'b0;
    push_value = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Refuse reads on empty stacks, ignore the unused action code
    send_cmd(ACT_POP, 1'b0, 32'h0);
    send_cmd(ACT_PEEK, 1'b1, 32'hFFFF_FFFF);
    send_cmd(ACT_NONE, 1'b1, 32'hFFFF_FFFF);

    // Extreme words on both stacks
    send_cmd(ACT_PUSH, 1'b0, 32'h8000_0000);
    send_cmd(ACT_PEEK, 1'b0, 32'h0);
    send_cmd(ACT_PUSH, 1'b1, 32'h7FFF_FFFF);
    send_cmd(ACT_PEEK, 1'b1, 32'h0);
    send_cmd(ACT_POP, 1'b1, 32'h0);

    // Fill the store, then refuse a push when full
    for (int k = 0; k < STORE_DEPTH - 1; k++)
      send_cmd(ACT_PUSH, k[0], (k[0] ? 32'hAAAA_AAAA : 32'h5555_5555) + k);
    send_cmd(ACT_PUSH, 1'b1, 32'hFFFF_FFFF);
    send_cmd(ACT_POP, 1'b0, 32'h0);
    send_cmd(ACT_POP, 1'b1, 32'h0);

    // Random traffic in phases that swing the stacks between empty and full
    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        r = $urandom_range(0, 2);
        push_pct = (r == 0) ? 80 : (r == 1) ? 20 : 50;
      end
      if (i % 150 == 75) drain();
      if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 17));
      r = $urandom_range(0, 99);
      if (r < 3) act = ACT_NONE;
      else if (r < 18) act = ACT_PEEK;
      else if ($urandom_range(0, 99) < push_pct) act = ACT_PUSH;
      else act = ACT_POP;
      send_cmd(act, 1'($urandom_range(0, 1)), $urandom);
    end

    // Wait out the last results
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
